@@ hdl/u8l1_pkg.sv @@
// Shared types and constants for the UTF-8 to Latin-1 decoder.
// No dependencies.
package u8l1_pkg;

	localparam logic [7:0] REPLACEMENT = 8'h5E;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_SKIP = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [4:0] lead_bits;
		logic [2:0] skip_remaining;
	} dec_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] char_out;
		logic       invalid;
	} dec_result_t;

endpackage

@@ hdl/utf8_to_latin1_decoder_core.sv @@
// Top level of the UTF-8 to Latin-1 decoder: input register, decode, result register.
// Depends on u8l1_pkg and u8l1_decode.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one UTF-8 byte per transfer with
//   end_of_string marking the last byte of a string. Output channel
//   (out_valid/out_stall) carries one Latin-1 character per transfer; invalid
//   is set when the replacement '^' stands for bad input.
//   Some bytes give no character (a held two-byte lead, skipped bytes of a
//   longer sequence); they still advance the decoder state.
//   Path: a character's last byte is decoded out of the input register
//   straight into the result register, with no register between the two.
//   Throughput: one byte per cycle while no stalled result holds the input
//   register, set by the single decode stage between the two registers.
//   Stall: while out_stall holds a waiting result, the input register holds
//   and in_stall rises once it is occupied; nothing is dropped or repeated.
//   Reset: arst_n clears both registers' valid flags and returns the decoder
//   to idle with no pending lead or skip count.
module utf8_to_latin1_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_out,
	output logic       invalid
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  eos_s1;
	logic                  advance;
	logic                  step;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  invalid_q;
	u8l1_pkg::dec_result_t result;
	u8l1_pkg::dec_state_t  state;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			eos_s1  <= end_of_string;
		end
	end

	u8l1_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (data_s1),
		.end_of_string (eos_s1),
		.result        (result),
		.state         (state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step && result.valid) begin
			char_q    <= result.char_out;
			invalid_q <= result.invalid;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign invalid   = invalid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && invalid_q |-> char_q == u8l1_pkg::REPLACEMENT)
		else $error("invalid result without replacement character");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && eos_s1 |=> state.mode == u8l1_pkg::MODE_IDLE
			&& state.lead_bits == 5'd0 && state.skip_remaining == 3'd0)
		else $error("decoder state not cleared after end of string");

	assert property (@(posedge clk) disable iff (!arst_n)
		state.mode == u8l1_pkg::MODE_SKIP |-> state.skip_remaining != 3'd0)
		else $error("skip mode with empty skip count");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && valid_s1 |-> in_stall)
		else $error("input register overwritten while result stalled");

endmodule

@@ hdl/u8l1_decode.sv @@
// Per-byte decode logic and decoder state registers.
// Depends on u8l1_pkg.
module u8l1_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_string,
	output u8l1_pkg::dec_result_t result,
	output u8l1_pkg::dec_state_t  state
);

	u8l1_pkg::dec_state_t state_q;
	u8l1_pkg::dec_state_t state_d;
	logic [10:0]          code_point;
	logic [2:0]           skip_len;
	logic [2:0]           skip_dec;

	assign code_point = {state_q.lead_bits, data_byte[5:0]};
	assign skip_dec   = (state_q.skip_remaining != 3'd0) ?
		state_q.skip_remaining - 3'd1 : state_q.skip_remaining;

	always_comb begin
		if ((data_byte & 8'hF0) == 8'hE0) begin
			skip_len = 3'd2;
		end else if ((data_byte & 8'hF8) == 8'hF0) begin
			skip_len = 3'd3;
		end else if ((data_byte & 8'hFC) == 8'hF8) begin
			skip_len = 3'd4;
		end else if ((data_byte & 8'hFE) == 8'hFC) begin
			skip_len = 3'd5;
		end else begin
			skip_len = 3'd0;
		end
	end

	always_comb begin
		state_d         = state_q;
		result.valid    = 1'b0;
		result.char_out = u8l1_pkg::REPLACEMENT;
		result.invalid  = 1'b1;
		case (state_q.mode)
			u8l1_pkg::MODE_WAIT: begin
				result.valid = 1'b1;
				if (data_byte[7:6] == 2'b10 && code_point[10:8] == 3'd0) begin
					result.char_out = code_point[7:0];
					result.invalid  = 1'b0;
				end
				state_d.mode      = u8l1_pkg::MODE_IDLE;
				state_d.lead_bits = 5'd0;
			end
			u8l1_pkg::MODE_SKIP: begin
				state_d.skip_remaining = skip_dec;
				if (skip_dec == 3'd0) begin
					state_d.mode = u8l1_pkg::MODE_IDLE;
				end
			end
			default: begin
				if (!data_byte[7]) begin
					result.valid    = 1'b1;
					result.char_out = data_byte;
					result.invalid  = 1'b0;
				end else if (data_byte[7:5] == 3'b110) begin
					if (!end_of_string) begin
						state_d.lead_bits = data_byte[4:0];
						state_d.mode      = u8l1_pkg::MODE_WAIT;
					end
				end else begin
					result.valid = 1'b1;
					if (skip_len != 3'd0) begin
						state_d.skip_remaining = skip_len;
						state_d.mode           = u8l1_pkg::MODE_SKIP;
					end
				end
			end
		endcase
		if (end_of_string) begin
			state_d.mode           = u8l1_pkg::MODE_IDLE;
			state_d.lead_bits      = 5'd0;
			state_d.skip_remaining = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= u8l1_pkg::MODE_IDLE;
			state_q.lead_bits      <= 5'd0;
			state_q.skip_remaining <= 3'd0;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

endmodule

@@ tb/sv/utf8_to_latin1_decoder_core_test.sv @@
// Self-checking testbench for utf8_to_latin1_decoder_core: directed and random UTF-8 strings,
// a per-byte decode predictor, and an in-order check of every character transfer.
// Depends on u8l1_pkg and the decoder RTL.
`timescale 1ns / 100ps

module utf8_to_latin1_decoder_core_test;

	typedef struct {
		logic [7:0] ch;
		logic       bad;
	} char_result_t;

	typedef enum {
		CK_ASCII,
		CK_LATIN,
		CK_WIDE,
		CK_BROKEN,
		CK_MULTI,
		CK_STRAY,
		CK_HIGH,
		CK_NOISE
	} char_kind_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       end_of_string;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] char_out;
	logic       invalid;

	char_result_t     expected_chars[$];
	char_result_t     want_char;
	u8l1_pkg::mode_t  pred_mode;
	logic [4:0]       pred_lead;
	logic [2:0]       pred_skip;
	int               mismatches = 0;
	int               bytes_sent = 0;
	int               hold_left = 0;
	int               stall_left = 0;
	bit               src_idle_on = 1'b1;
	bit               sink_idle_on = 1'b1;

	utf8_to_latin1_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.char_out     (char_out),
		.invalid      (invalid)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void expect_char(input logic [7:0] ch, input logic bad);
		char_result_t r;
		r.ch = ch;
		r.bad = bad;
		expected_chars.insert(expected_chars.size(), r);
	endfunction

	function automatic void predict_decode(input logic [7:0] b, input logic eos);
		logic [10:0] code;
		logic [2:0]  skip;
		if (pred_mode == u8l1_pkg::MODE_WAIT) begin
			if (b[7:6] == 2'b10) begin
				code = {pred_lead, b[5:0]};
				if (code > 11'h0FF)
					expect_char(u8l1_pkg::REPLACEMENT, 1'b1);
				else
					expect_char(code[7:0], 1'b0);
			end else begin
				expect_char(u8l1_pkg::REPLACEMENT, 1'b1);
			end
			pred_mode = u8l1_pkg::MODE_IDLE;
			pred_lead = '0;
		end else if (pred_mode == u8l1_pkg::MODE_SKIP) begin
			if (pred_skip != 3'd0)
				pred_skip = pred_skip - 3'd1;
			if (pred_skip == 3'd0)
				pred_mode = u8l1_pkg::MODE_IDLE;
		end else begin
			if (!b[7]) begin
				expect_char(b, 1'b0);
			end else if (b[7:5] == 3'b110) begin
				if (!eos) begin
					pred_lead = b[4:0];
					pred_mode = u8l1_pkg::MODE_WAIT;
				end
			end else begin
				if (b[7:4] == 4'b1110)
					skip = 3'd2;
				else if (b[7:3] == 5'b11110)
					skip = 3'd3;
				else if (b[7:2] == 6'b111110)
					skip = 3'd4;
				else if (b[7:1] == 7'b1111110)
					skip = 3'd5;
				else
					skip = 3'd0;
				expect_char(u8l1_pkg::REPLACEMENT, 1'b1);
				if (skip != 3'd0) begin
					pred_skip = skip;
					pred_mode = u8l1_pkg::MODE_SKIP;
				end
			end
		end
		if (eos) begin
			pred_mode = u8l1_pkg::MODE_IDLE;
			pred_lead = '0;
			pred_skip = '0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eos);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_string <= eos;
		predict_decode(b, eos);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// check each character transfer, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%h invalid %b", char_out, invalid));
			end else begin
				want_char = expected_chars.pop_front();
				if (char_out !== want_char.ch)
					report_mismatch($sformatf("char_out 0x%h, want 0x%h", char_out, want_char.ch));
				if (invalid !== want_char.bad)
					report_mismatch($sformatf("invalid %b, want %b", invalid, want_char.bad));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_ascii();
		send_byte(8'h00, 1'b0);
		send_byte(8'h5E, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	task automatic test_two_byte();
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		// above 0xFF
		send_byte(8'hC4, 1'b0);
		send_byte(8'h80, 1'b0);
		// overlong, decoded as is
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		// non-continuation is consumed
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b1);
		// lead on the last byte gives nothing
		send_byte(8'hDF, 1'b1);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_long_leads();
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		// skip cut short by the end of the string
		send_byte(8'hE2, 1'b0);
		send_byte(8'h81, 1'b1);
		send_byte(8'hFC, 1'b1);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic send_random_string();
		logic [7:0] seq[$];
		logic [7:0] b;
		char_kind_t kind;
		int         n_chars;
		int         len;
		int         pick;
		int         cut;
		n_chars = $urandom_range(1, 10);
		for (int c = 0; c < n_chars; c++) begin
			pick = $urandom_range(0, 15);
			if (pick < 5)
				kind = CK_ASCII;
			else if (pick < 8)
				kind = CK_LATIN;
			else if (pick < 9)
				kind = CK_WIDE;
			else if (pick < 10)
				kind = CK_BROKEN;
			else if (pick < 13)
				kind = CK_MULTI;
			else if (pick < 14)
				kind = CK_STRAY;
			else if (pick < 15)
				kind = CK_HIGH;
			else
				kind = CK_NOISE;
			case (kind)
				CK_ASCII: begin
					seq.insert(seq.size(), 8'($urandom_range(0, 127)));
				end
				CK_LATIN: begin
					seq.insert(seq.size(), 8'(8'hC2 + $urandom_range(0, 1)));
					seq.insert(seq.size(), 8'(8'h80 + $urandom_range(0, 63)));
				end
				CK_WIDE: begin
					seq.insert(seq.size(), 8'(8'hC0 + $urandom_range(0, 31)));
					seq.insert(seq.size(), 8'(8'h80 + $urandom_range(0, 63)));
				end
				CK_BROKEN: begin
					seq.insert(seq.size(), 8'(8'hC0 + $urandom_range(0, 31)));
					b = 8'($urandom_range(0, 255));
					if (b[7:6] == 2'b10)
						b[7] = 1'b0;
					seq.insert(seq.size(), b);
				end
				CK_MULTI: begin
					len = $urandom_range(3, 6);
					seq.insert(seq.size(),
						8'((8'hFF << (8 - len)) | ($urandom & (8'hFF >> (len + 1)))));
					for (int k = 1; k < len; k++) begin
						if ($urandom_range(0, 3) == 0)
							seq.insert(seq.size(), 8'($urandom_range(0, 255)));
						else
							seq.insert(seq.size(), 8'(8'h80 + $urandom_range(0, 63)));
					end
				end
				CK_STRAY: begin
					seq.insert(seq.size(), 8'(8'h80 + $urandom_range(0, 63)));
				end
				CK_HIGH: begin
					seq.insert(seq.size(), 8'(8'hFE + $urandom_range(0, 1)));
				end
				default: begin
					seq.insert(seq.size(), 8'($urandom_range(0, 255)));
				end
			endcase
		end
		cut = seq.size() - 1;
		if ($urandom_range(0, 7) == 0)
			cut = $urandom_range(0, seq.size() - 1);
		for (int i = 0; i <= cut; i++)
			send_byte(seq[i], i == cut);
	endtask

	task automatic test_backpressure();
		bit saved_idle;
		saved_idle = src_idle_on;
		src_idle_on = 1'b0;
		hold_left = 80;
		repeat (24)
			send_byte(8'($urandom_range(0, 127)), 1'b0);
		send_byte(8'h41, 1'b1);
		src_idle_on = saved_idle;
	endtask

	task automatic test_random(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes)
			send_random_string();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		end_of_string = 1'b0;
		out_stall = 1'b0;
		pred_mode = u8l1_pkg::MODE_IDLE;
		pred_lead = '0;
		pred_skip = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii();
		test_two_byte();
		test_long_leads();
		test_backpressure();
		test_random(350);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		test_random(100);

		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/u8l1_pkg.sv
hdl/u8l1_decode.sv
hdl/utf8_to_latin1_decoder_core.sv
tb/sv/utf8_to_latin1_decoder_core_test.sv
